// ===== src/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Shared sizes, operation and status codes, and the cell command bundle for
// the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY = 64;
    // Wide enough to hold the count itself (0..CAPACITY)
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Compare width for the 8-bit index against the count
    localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;
    localparam int WORD_W   = 64;

    typedef enum logic [2:0] {
        K_APPEND     = 3'd0,
        K_INSERT     = 3'd1,
        K_GET        = 3'd2,
        K_SET        = 3'd3,
        K_REMOVE     = 3'd4,
        K_TAKE_LAST  = 3'd5,
        K_TAKE_FIRST = 3'd6,
        K_FIND       = 3'd7
    } kind_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [6:0] POS_NONE = 7'h7F;

    // Broadcast to every cell for one operation
    typedef struct packed {
        logic             load_en;  // load the operand word at load_at
        logic [CNT_W-1:0] load_at;
        logic             up_en;    // take left word where lo < pos <= hi
        logic             dn_en;    // take right word where pos >= lo
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
    } cell_cmd_t;

endpackage

// ===== src/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// One list entry: holds a word, loads the operand, or takes the word of its
// left or right neighbor. Flags a match against the operand.
// ----------------------------------------------------------------------------
module ils_cell
    import ils_pkg::*;
(
    input  logic              clk,
    input  logic              step,
    input  cell_cmd_t         cmd,
    input  logic [CNT_W-1:0]  pos,
    input  logic [WORD_W-1:0] operand,
    input  logic [WORD_W-1:0] left_word,
    input  logic [WORD_W-1:0] right_word,
    output logic [WORD_W-1:0] word,
    output logic              match
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (cmd.load_en && (pos == cmd.load_at))
        begin
            word_next = operand;
        end
        else if (cmd.up_en && (pos > cmd.lo) && (pos <= cmd.hi))
        begin
            word_next = left_word;
        end
        else if (cmd.dn_en && (pos >= cmd.lo))
        begin
            word_next = right_word;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            word_reg <= word_next;
        end
    end

    assign word  = word_reg;
    assign match = (word_reg == operand);

endmodule

// ===== src/ils_find.sv =====
// ----------------------------------------------------------------------------
// ils_find
// Lowest-set-bit encoder over the registered per-cell match flags.
// ----------------------------------------------------------------------------
module ils_find
    import ils_pkg::*;
(
    input  logic [CAPACITY-1:0] hits,
    output logic                found,
    output logic [CNT_W-1:0]    first
);

    always_comb
    begin
        found = 1'b0;
        first = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                found = 1'b1;
                first = CNT_W'(i);
            end
        end
    end

endmodule

// ===== src/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of 64-bit words in a row of cells, one cell per entry.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------
//  command   | kind, index, value                        | start & !busy
//  result    | read_value, status, position, length_now  | done, one cycle
//
//  Each word passes through accept, execute (all cells shift/load at once,
//  match flags and read word captured), report (find encoder, done pulse).
//  busy stays high through execute and report; next accept is in idle.
//  rst_n clears the count and the control; cell contents stay undefined,
//  only entries below the count are ever read.
//  The receiver cannot stall: done is high for exactly one cycle.
//
module indexed_list_store
    import ils_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        kind,
    input  logic signed [7:0] index,
    input  logic [WORD_W-1:0] value,
    output logic              done,
    output logic [WORD_W-1:0] read_value,
    output logic [1:0]        status,
    output logic signed [6:0] position,
    output logic [6:0]        length_now
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_REPORT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // latched command word
    kind_t             kind_reg;
    logic [7:0]        index_reg;
    logic [WORD_W-1:0] value_reg;

    logic [CNT_W-1:0]  count_reg, count_next;

    // result registers
    logic [WORD_W-1:0] rd_reg, rd_next;
    logic [1:0]        st_reg, st_next;
    logic [CAPACITY-1:0] hits_reg;
    logic              is_find_reg;

    logic accept;
    logic step;

    assign accept = start && (state_reg == S_IDLE);
    assign step   = (state_reg == S_EXEC);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (start) state_next = S_EXEC;
            S_EXEC:   state_next = S_REPORT;
            S_REPORT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (step)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_t'(kind);
            index_reg <= index;
            value_reg <= value;
        end
    end

    // ---- operation decode (execute cycle) ---------------------------------
    logic [CMP_W-1:0] idx_c;
    logic [CMP_W-1:0] cnt_c;
    logic             idx_neg;
    logic             in_range;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] idx_pos;
    logic [CNT_W-1:0] ins_at;
    cell_cmd_t        cmd;
    logic             rd_en;
    logic [CNT_W-1:0] rd_at;

    assign idx_neg  = index_reg[7];
    assign idx_c    = CMP_W'(index_reg[6:0]);
    assign cnt_c    = CMP_W'(count_reg);
    assign in_range = !idx_neg && (idx_c < cnt_c);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign idx_pos  = CNT_W'(index_reg[6:0]);

    // insert position clamped to 0..count
    always_comb
    begin
        if (idx_neg)
            ins_at = '0;
        else if (idx_c > cnt_c)
            ins_at = count_reg;
        else
            ins_at = idx_pos;
    end

    always_comb
    begin
        cmd        = '0;
        rd_en      = 1'b0;
        rd_at      = '0;
        st_next    = ST_OK;
        count_next = count_reg;
        case (kind_reg)
            K_APPEND:
            begin
                if (full)
                    st_next = ST_FULL;
                else
                begin
                    cmd.load_en = 1'b1;
                    cmd.load_at = count_reg;
                    count_next  = count_reg + 1'b1;
                end
            end
            K_INSERT:
            begin
                if (full)
                    st_next = ST_FULL;
                else
                begin
                    cmd.load_en = 1'b1;
                    cmd.load_at = ins_at;
                    cmd.up_en   = 1'b1;
                    cmd.lo      = ins_at;
                    cmd.hi      = count_reg;
                    count_next  = count_reg + 1'b1;
                end
            end
            K_GET:
            begin
                if (in_range)
                begin
                    rd_en = 1'b1;
                    rd_at = idx_pos;
                end
                else
                    st_next = ST_INDEX;
            end
            K_SET:
            begin
                if (in_range)
                begin
                    cmd.load_en = 1'b1;
                    cmd.load_at = idx_pos;
                end
                else
                    st_next = ST_INDEX;
            end
            K_REMOVE:
            begin
                if (in_range)
                begin
                    cmd.dn_en  = 1'b1;
                    cmd.lo     = idx_pos;
                    count_next = count_reg - 1'b1;
                end
                else
                    st_next = ST_INDEX;
            end
            K_TAKE_LAST:
            begin
                if (empty)
                    st_next = ST_INDEX;
                else
                begin
                    rd_en      = 1'b1;
                    rd_at      = count_reg - 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            K_TAKE_FIRST:
            begin
                if (empty)
                    st_next = ST_INDEX;
                else
                begin
                    rd_en      = 1'b1;
                    rd_at      = '0;
                    cmd.dn_en  = 1'b1;
                    cmd.lo     = '0;
                    count_next = count_reg - 1'b1;
                end
            end
            K_FIND:    ;
            default:   ;
        endcase
    end

    // ---- cell row ---------------------------------------------------------
    logic [WORD_W-1:0]   words [CAPACITY];
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] valid_pos;

    for (genvar p = 0; p < CAPACITY; p++)
    begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (p == 0)
        begin : g_first
            assign left_w = value_reg;
        end
        else
        begin : g_mid_l
            assign left_w = words[p-1];
        end

        if (p == CAPACITY - 1)
        begin : g_last
            assign right_w = words[p];
        end
        else
        begin : g_mid_r
            assign right_w = words[p+1];
        end

        ils_cell u_cell (
            .clk        (clk),
            .step       (step),
            .cmd        (cmd),
            .pos        (CNT_W'(p)),
            .operand    (value_reg),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[p]),
            .match      (match[p])
        );

        assign valid_pos[p] = (CNT_W'(p) < count_reg);
    end

    // read tap: AND-OR over the row, pre-operation contents
    always_comb
    begin
        rd_next = '0;
        for (int p = 0; p < CAPACITY; p++)
        begin
            if (rd_en && (rd_at == CNT_W'(p)))
                rd_next = rd_next | words[p];
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rd_reg      <= rd_next;
            st_reg      <= st_next;
            hits_reg    <= match & valid_pos;
            is_find_reg <= (kind_reg == K_FIND);
        end
    end

    // ---- report -----------------------------------------------------------
    logic             found;
    logic [CNT_W-1:0] first;

    ils_find u_find (
        .hits  (hits_reg),
        .found (found),
        .first (first)
    );

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_REPORT);
    assign read_value = rd_reg;
    assign status     = st_reg;
    assign position   = !is_find_reg ? 7'sd0 : (found ? $signed(7'(first)) : $signed(POS_NONE));
    assign length_now = 7'(count_reg);

endmodule

// ===== src/ils_checker.sv =====
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks for the indexed list store, bound to the top level.
// ----------------------------------------------------------------------------
module ils_checker
    import ils_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [1:0]        status,
    input logic [6:0]        length_now
);

    // an accepted word occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not raise busy");

    // one result per word: no back-to-back strobes
    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held more than one cycle");

    // result only while busy, and the block frees right after
    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy ##1 !busy)
        else $error("done outside busy window");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_INDEX || status == ST_FULL))
        else $error("bad status code");

    // full reported only at capacity
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (length_now == 7'(CAPACITY)))
        else $error("full status below capacity");

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);

// ===== verif/indexed_list_store_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_tb
// Self-checking bench for the indexed list store. A directed opener covers
// the empty list, index clamping, range errors and find hits and misses.
// Random segments then grow, shrink, fill and mix the list, with bursty
// command timing. Each accepted word is run through a local list model, and
// every done pulse is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module indexed_list_store_tb
    import ils_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1900;

    // Shape of a random segment
    localparam int M_GROW   = 0;
    localparam int M_SHRINK = 1;
    localparam int M_MIX    = 2;
    localparam int M_FILL   = 3;

    typedef struct packed {
        kind_t              op;
        logic signed [7:0]  idx;
        logic [WORD_W-1:0]  word;
        logic               hold;   // wait for all results before issuing
    } list_cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0]  rd;
        logic [1:0]         st;
        logic signed [6:0]  pos;
        logic [6:0]         len;
    } list_reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [2:0]        kind = '0;
    logic signed [7:0] index = '0;
    logic [WORD_W-1:0] value = '0;
    logic              done;
    logic [WORD_W-1:0] read_value;
    logic [1:0]        status;
    logic signed [6:0] position;
    logic [6:0]        length_now;

    indexed_list_store DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .index      (index),
        .value      (value),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .position   (position),
        .length_now (length_now)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Local list model: contents and length as seen after each accepted word
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0] list_words [CAPACITY];
    int                list_len = 0;

    list_cmd_t   cmd_queue [$];          // words still to be issued
    list_reply_t expected_replies [$];   // predictions awaiting a done pulse
    int          in_flight = 0;          // accepted words not yet answered
    int          fail_count = 0;

    // Applies one word to the local list and returns the result it should give
    function automatic list_reply_t apply_op(list_cmd_t c);
        list_reply_t r;
        int          at;
        bit          in_range;
        r.rd     = '0;
        r.st     = ST_OK;
        r.pos    = '0;
        at       = c.idx;                 // sign-extended
        in_range = (at >= 0) && (at < list_len);
        case (c.op)
            K_APPEND:
            begin
                if (list_len >= CAPACITY) r.st = ST_FULL;
                else
                begin
                    list_words[list_len] = c.word;
                    list_len++;
                end
            end
            K_INSERT:
            begin
                if (list_len >= CAPACITY) r.st = ST_FULL;
                else
                begin
                    // out-of-range insert positions clamp to the ends
                    if (at < 0) at = 0;
                    else if (at > list_len) at = list_len;
                    for (int i = list_len; i > at; i--) list_words[i] = list_words[i-1];
                    list_words[at] = c.word;
                    list_len++;
                end
            end
            K_GET:
            begin
                if (in_range) r.rd = list_words[at];
                else r.st = ST_INDEX;
            end
            K_SET:
            begin
                if (in_range) list_words[at] = c.word;
                else r.st = ST_INDEX;
            end
            K_REMOVE:
            begin
                if (in_range)
                begin
                    for (int i = at + 1; i < list_len; i++) list_words[i-1] = list_words[i];
                    list_len--;
                end
                else r.st = ST_INDEX;
            end
            K_TAKE_LAST:
            begin
                if (list_len == 0) r.st = ST_INDEX;
                else
                begin
                    r.rd = list_words[list_len-1];
                    list_len--;
                end
            end
            K_TAKE_FIRST:
            begin
                if (list_len == 0) r.st = ST_INDEX;
                else
                begin
                    r.rd = list_words[0];
                    for (int i = 1; i < list_len; i++) list_words[i-1] = list_words[i];
                    list_len--;
                end
            end
            default:
            begin
                // find: first match wins, none gives all ones
                r.pos = POS_NONE;
                for (int i = list_len - 1; i >= 0; i--)
                    if (list_words[i] == c.word) r.pos = 7'(i);
            end
        endcase
        r.len = 7'(list_len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Command driver: bursts of words with random gaps between them.
    // A word flagged hold waits until every earlier word has been answered.
    // ------------------------------------------------------------------------
    list_cmd_t shown_cmd;
    int        burst_left = 1;
    int        gap_left = 0;

    always @(posedge clk)
    begin : drive
        bit took;
        bit show_next;
        bit fresh;
        if (rst_n)
        begin
            took  = start && !busy;
            fresh = 1'b0;
            if (took)
            begin
                expected_replies.insert(expected_replies.size(), apply_op(shown_cmd));
                in_flight++;
            end
            if (done) in_flight--;

            // a word not yet taken stays on the ports
            show_next = start && !took;
            if (!show_next)
            begin
                if (gap_left > 0) gap_left--;
                else if (cmd_queue.size() > 0 && (!cmd_queue[0].hold || in_flight == 0))
                begin
                    shown_cmd = cmd_queue[0];
                    cmd_queue.delete(0);
                    show_next = 1'b1;
                    fresh     = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // about a quarter of the bursts run straight on
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end

            if (fresh)
            begin
                kind  <= shown_cmd.op;
                index <= shown_cmd.idx;
                value <= shown_cmd.word;
            end
            else if (!show_next)
            begin
                // junk on the payload while start is low must be ignored
                kind  <= 3'($urandom_range(0, 7));
                index <= 8'($urandom_range(0, 255));
                value <= {$urandom, $urandom};
            end
            start <= show_next;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: done is a one-cycle strobe, checked against the oldest
    // prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check
        list_reply_t want;
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                want = expected_replies[0];
                expected_replies.delete(0);
                if (read_value !== want.rd)
                begin
                    $error("read_value: expected %h, got %h", want.rd, read_value);
                    fail_count++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    fail_count++;
                end
                if (position !== want.pos)
                begin
                    $error("position: expected %0d, got %0d", want.pos, position);
                    fail_count++;
                end
                if (length_now !== want.len)
                begin
                    $error("length_now: expected %0d, got %0d", want.len, length_now);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus plan. plan_len follows the list length only to aim indexes
    // near the valid range.
    // ------------------------------------------------------------------------
    int                plan_len = 0;
    int                queued_total = 0;
    logic [WORD_W-1:0] word_pool [8];

    task automatic queue_cmd(kind_t k, int ix, logic [WORD_W-1:0] w, bit hold);
        list_cmd_t c;
        c.op   = k;
        c.idx  = 8'(ix);
        c.word = w;
        c.hold = hold;
        cmd_queue.insert(cmd_queue.size(), c);
        queued_total++;
        case (k)
            K_APPEND, K_INSERT:        if (plan_len < CAPACITY) plan_len++;
            K_REMOVE:                  if (c.idx >= 0 && c.idx < plan_len) plan_len--;
            K_TAKE_LAST, K_TAKE_FIRST: if (plan_len > 0) plan_len--;
            default: ;
        endcase
    endtask

    initial
    begin : stimulus
        int                mode;
        int                seg_len;
        int                r;
        int                ix;
        kind_t             k;
        logic [WORD_W-1:0] w;

        word_pool[0] = '0;
        word_pool[1] = '1;
        for (int i = 2; i < 8; i++) word_pool[i] = {$urandom, $urandom};

        // Directed: everything on the empty list fails or misses
        queue_cmd(K_GET,        0,    '0, 1'b1);
        queue_cmd(K_TAKE_LAST,  0,    '0, 1'b0);
        queue_cmd(K_TAKE_FIRST, 0,    '0, 1'b0);
        queue_cmd(K_FIND,       0,    '0, 1'b0);
        queue_cmd(K_REMOVE,     0,    '0, 1'b0);
        queue_cmd(K_SET,        0,    '1, 1'b0);
        // build [A, C, ones, zero, B] through both insert clamps
        queue_cmd(K_APPEND,     0,    '1, 1'b0);
        queue_cmd(K_APPEND,     0,    '0, 1'b0);
        queue_cmd(K_INSERT,     -128, 64'h0123_4567_89AB_CDEF, 1'b0);
        queue_cmd(K_INSERT,     127,  64'hFEDC_BA98_7654_3210, 1'b0);
        queue_cmd(K_INSERT,     1,    64'h8000_0000_0000_0001, 1'b0);
        // edges of the index range
        queue_cmd(K_GET,        0,    '0, 1'b0);
        queue_cmd(K_GET,        4,    '0, 1'b0);
        queue_cmd(K_GET,        5,    '0, 1'b0);
        queue_cmd(K_GET,        -1,   '0, 1'b0);
        queue_cmd(K_SET,        2,    64'h5A5A_A5A5_0F0F_F0F0, 1'b0);
        queue_cmd(K_FIND,       0,    64'h5A5A_A5A5_0F0F_F0F0, 1'b0);
        queue_cmd(K_FIND,       0,    '0, 1'b0);
        queue_cmd(K_FIND,       0,    64'h1111_2222_3333_4444, 1'b0);
        queue_cmd(K_REMOVE,     2,    '0, 1'b0);
        queue_cmd(K_REMOVE,     -128, '0, 1'b0);
        queue_cmd(K_TAKE_LAST,  0,    '0, 1'b0);
        queue_cmd(K_TAKE_FIRST, 0,    '0, 1'b0);
        queue_cmd(K_SET,        127,  '1, 1'b0);
        queue_cmd(K_GET,        127,  '0, 1'b0);

        // Random segments, each opened by a word that waits for a drained block
        while (queued_total < 25 + RANDOM_WORDS)
        begin
            mode    = $urandom_range(M_GROW, M_FILL);
            seg_len = (mode == M_FILL) ? CAPACITY - plan_len + $urandom_range(1, 6)
                                       : $urandom_range(40, 150);
            for (int n = 0; n < seg_len; n++)
            begin
                r = $urandom_range(0, 99);
                case (mode)
                    M_GROW:
                    begin
                        if (r < 45) k = K_APPEND;
                        else if (r < 75) k = K_INSERT;
                        else if (r < 80) k = K_GET;
                        else if (r < 85) k = K_SET;
                        else if (r < 90) k = K_REMOVE;
                        else if (r < 93) k = K_TAKE_LAST;
                        else if (r < 96) k = K_TAKE_FIRST;
                        else k = K_FIND;
                    end
                    M_SHRINK:
                    begin
                        if (r < 10) k = K_APPEND;
                        else if (r < 15) k = K_INSERT;
                        else if (r < 35) k = K_REMOVE;
                        else if (r < 55) k = K_TAKE_LAST;
                        else if (r < 75) k = K_TAKE_FIRST;
                        else if (r < 83) k = K_GET;
                        else if (r < 90) k = K_SET;
                        else k = K_FIND;
                    end
                    M_FILL: k = (r < 30) ? K_INSERT : K_APPEND;
                    default: k = kind_t'($urandom_range(0, 7));
                endcase

                // mostly in range or just past the end, some anywhere in 8 bits
                r = $urandom_range(0, 9);
                if (r < 7) ix = $urandom_range(0, plan_len);
                else if (r < 8) ix = plan_len - 1;
                else ix = $urandom_range(0, 255);

                // pooled words make find hit, often on duplicates
                w = ($urandom_range(0, 1) == 0) ? word_pool[$urandom_range(0, 7)]
                                                : {$urandom, $urandom};
                queue_cmd(k, ix, w, n == 0);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // settle on falling edges, clear of the driver and monitor updates
        do
            @(negedge clk);
        while (cmd_queue.size() != 0 || start || in_flight != 0 ||
               expected_replies.size() != 0);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("[indexed_list_store] OK");
        else
            $display("[indexed_list_store] ERROR");
        $finish;
    end

    // Watchdog, far above the slowest clean run
    initial
    begin : watchdog
        #5ms;
        $display("[indexed_list_store] ERROR");
        $finish;
    end

endmodule
